// ===== hw/rtl/sparse_input_relu_mlp_eval_core_macros.svh =====
`ifndef SPARSE_INPUT_RELU_MLP_EVAL_CORE_MACROS_SVH
`define SPARSE_INPUT_RELU_MLP_EVAL_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define SRME_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srme: same-cycle check failed");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define SRME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srme: next-cycle check failed");

`endif

// ===== hw/rtl/srme_pkg.sv =====
package srme_pkg;

  // word field widths
  localparam int FuncW    = 3;
  localparam int RowW     = 10;
  localparam int ColW     = 6;
  localparam int ValW     = 16;
  localparam int ScoreW   = 20;
  localparam int OutBiasW = 24;

  // fixed point
  localparam int AccW     = 24;
  localparam int ExtW     = 34;
  localparam int FracBits = 12;

  localparam logic signed [ExtW-1:0] AccHi = 34'sd8388607;
  localparam logic signed [ExtW-1:0] AccLo = -34'sd8388608;

  localparam logic [ScoreW-1:0] ScoreMin = 20'd2048;
  localparam logic [ScoreW-1:0] ScoreMax = 20'hFFFFF;

  // one in q24 plus the rounding half of the final shift
  localparam longint ScaleOffset = (longint'(1) <<< 24) + longint'(2048);
  // half in q24, moved by the same rounding half
  localparam longint LowBound    = (longint'(1) <<< 23) + longint'(2048);

  typedef enum logic [FuncW-1:0] {
    FUNC_WR_IN_W  = 3'd0,
    FUNC_WR_BIAS  = 3'd1,
    FUNC_WR_OUT_W = 3'd2,
    FUNC_ADD_FEAT = 3'd3,
    FUNC_EVAL     = 3'd4
  } func_e;

  typedef struct packed {
    logic [FuncW-1:0]       func;
    logic [RowW-1:0]        row_index;
    logic [ColW-1:0]        column_index;
    logic signed [ValW-1:0] weight_value;
  } req_t;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic              overflow;
  } rsp_t;

  // field write enables of the hidden unit memory
  typedef struct packed {
    logic acc;
    logic bias;
    logic outw;
  } hwr_en_t;

  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [ExtW-1:0] v);
    logic signed [AccW-1:0] r;
    if (v > AccHi) begin
      r = AccHi[AccW-1:0];
    end else if (v < AccLo) begin
      r = AccLo[AccW-1:0];
    end else begin
      r = v[AccW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/srme_if.sv =====
interface srme_req_if;
  logic              valid;
  logic              ready;
  srme_pkg::req_t    payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface srme_rsp_if;
  logic              valid;
  logic              ready;
  srme_pkg::rsp_t    payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/sparse_input_relu_mlp_eval_core.sv =====
// timing: a load word leaves ready high, so load words can be taken back to back;
// a feature word holds ready low until its walk drains, and an evaluate word until
// its score has passed the score unit into the output register, once there is room
// throughput: one hidden unit per cycle through the hidden unit memory read port
// reset: asynchronous, active low; a clearing pass then zeroes the accumulators, with
// ready low; weight and bias tables stay undefined until written
module sparse_input_relu_mlp_eval_core #(
  parameter int INPUT_COUNT  = 1024,
  parameter int HIDDEN_COUNT = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic signed [srme_pkg::OutBiasW-1:0] cfg_wdata_i,
  srme_req_if.sink                            req_i,
  srme_rsp_if.source                          rsp_o
);

  localparam int AccW       = srme_pkg::AccW;
  localparam int ExtW       = srme_pkg::ExtW;
  localparam int TableDepth = INPUT_COUNT * HIDDEN_COUNT;
  localparam int TabAddrW   = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int HidW       = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
  localparam int ProdW      = WEIGHT_BITS + AccW;
  localparam int BiasTermW  = srme_pkg::OutBiasW + srme_pkg::FracBits;
  // room for every product plus the output bias term, exact
  localparam int SumW       = ((ProdW > BiasTermW) ? ProdW : BiasTermW) + HidW + 1;

  localparam logic signed [ExtW-1:0] WMax =
    ExtW'((longint'(1) <<< (WEIGHT_BITS - 1)) - longint'(1));
  localparam logic signed [ExtW-1:0] WMin =
    ExtW'(-(longint'(1) <<< (WEIGHT_BITS - 1)));

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FEAT,
    ST_EVAL,
    ST_SCORE
  } state_e;

  // control
  state_e                      state_q, state_d;
  logic [HidW-1:0]             idx_q, idx_d;
  logic                        issue_q, issue_d;
  logic                        s1_v_q, s1_v_d;
  logic                        s2_v_q, s2_v_d;
  logic                        s3_v_q, s3_v_d;
  logic                        out_v_q, out_v_d;
  logic signed [srme_pkg::OutBiasW-1:0] output_bias_q;

  // datapath
  logic [HidW-1:0]             s1_idx_q;
  logic [TabAddrW-1:0]         taddr_q;
  logic [AccW-2:0]             h_q, h_d;
  logic [WEIGHT_BITS-1:0]      ow_q;
  logic signed [ProdW-1:0]     prod_q;
  logic signed [SumW-1:0]      sum_q, sum_init;
  srme_pkg::rsp_t              out_q;

  srme_pkg::req_t              req;
  logic                        accept, row_ok, col_ok, last_idx, drained;
  logic [TabAddrW-1:0]         tab_waddr, row_base;
  logic signed [ExtW-1:0]      w_ext, w_sat;
  logic [WEIGHT_BITS-1:0]      w_store;

  // memory ports
  logic                        wmem_we, wmem_re;
  logic [WEIGHT_BITS-1:0]      wmem_rdata;
  srme_pkg::hwr_en_t           hmem_wen;
  logic [HidW-1:0]             hmem_waddr;
  logic signed [AccW-1:0]      hmem_wacc, hmem_racc;
  logic [WEIGHT_BITS-1:0]      hmem_rbias, hmem_routw;
  logic signed [AccW-1:0]      feat_acc, h_full;

  // score unit
  logic                        score_start, score_vld, load;
  srme_pkg::rsp_t              score_res;

  assign req    = req_i.payload;
  assign accept = req_i.valid && req_i.ready;
  assign row_ok = 32'(req.row_index) < 32'(INPUT_COUNT);
  assign col_ok = 32'(req.column_index) < 32'(HIDDEN_COUNT);

  // row-major weight table: one row of hidden weights per feature
  assign row_base  = TabAddrW'(32'(req.row_index) * 32'(HIDDEN_COUNT));
  assign tab_waddr = TabAddrW'(32'(req.row_index) * 32'(HIDDEN_COUNT)
                               + 32'(req.column_index));

  // stored weights are clamped to the table's signed range
  assign w_ext   = ExtW'(req.weight_value);
  assign w_sat   = (w_ext > WMax) ? WMax : ((w_ext < WMin) ? WMin : w_ext);
  assign w_store = w_sat[WEIGHT_BITS-1:0];

  assign last_idx = (idx_q == HidW'(HIDDEN_COUNT - 1));
  assign drained  = !issue_q && !s1_v_q && !s2_v_q && !s3_v_q;
  assign sum_init = SumW'(output_bias_q) <<< srme_pkg::FracBits;

  // read side of the walk: weight row and hidden unit entry at the same index
  assign wmem_we = accept && (req.func == srme_pkg::FUNC_WR_IN_W) && row_ok && col_ok;
  assign wmem_re = issue_q && (state_q == ST_FEAT);

  srme_wmem #(
    .Depth (TableDepth),
    .Width (WEIGHT_BITS),
    .AddrW (TabAddrW)
  ) u_wmem (
    .clk_i   (clk_i),
    .we_i    (wmem_we),
    .waddr_i (tab_waddr),
    .wdata_i (w_store),
    .re_i    (wmem_re),
    .raddr_i (taddr_q),
    .rdata_o (wmem_rdata)
  );

  // saturating feature add, and the biased hidden value with relu
  assign feat_acc = srme_pkg::sat_acc(ExtW'(hmem_racc) + ExtW'($signed(wmem_rdata)));
  assign h_full   = srme_pkg::sat_acc(ExtW'(hmem_racc) + ExtW'($signed(hmem_rbias)));
  assign h_d      = (!h_full[AccW-1] && (h_full != '0)) ? h_full[AccW-2:0] : '0;

  // write side: the entry read last cycle is written back, so the walk never
  // reads an entry with a write still pending; the walk drains before idle
  always_comb begin
    hmem_wen   = '0;
    hmem_waddr = s1_idx_q;
    hmem_wacc  = '0;
    case (state_q)
      ST_CLEAR: begin
        hmem_wen.acc = 1'b1;
        hmem_waddr   = idx_q;
      end
      ST_IDLE: begin
        hmem_waddr = HidW'(req.column_index);
        if (accept && col_ok) begin
          hmem_wen.bias = (req.func == srme_pkg::FUNC_WR_BIAS);
          hmem_wen.outw = (req.func == srme_pkg::FUNC_WR_OUT_W);
        end
      end
      ST_FEAT: begin
        hmem_wen.acc = s1_v_q;
        hmem_wacc    = feat_acc;
      end
      ST_EVAL: begin
        // accumulators cleared as the evaluate walk passes
        hmem_wen.acc = s1_v_q;
      end
      default: begin
        hmem_wen = '0;
      end
    endcase
  end

  srme_hmem #(
    .Depth (HIDDEN_COUNT),
    .WBits (WEIGHT_BITS),
    .AddrW (HidW)
  ) u_hmem (
    .clk_i   (clk_i),
    .wen_i   (hmem_wen),
    .waddr_i (hmem_waddr),
    .wacc_i  (hmem_wacc),
    .wbias_i (w_store),
    .woutw_i (w_store),
    .re_i    (issue_q),
    .raddr_i (idx_q),
    .racc_o  (hmem_racc),
    .rbias_o (hmem_rbias),
    .routw_o (hmem_routw)
  );

  assign score_start = (state_q == ST_EVAL) && drained;
  assign load        = (state_q == ST_SCORE) && score_vld && (!out_v_q || rsp_o.ready);

  srme_score #(
    .SumW (SumW)
  ) u_score (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (score_start),
    .sum_i    (sum_q),
    .take_i   (load),
    .valid_o  (score_vld),
    .result_o (score_res)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    issue_d = issue_q;
    s1_v_d  = issue_q;
    s2_v_d  = s1_v_q && (state_q == ST_EVAL);
    s3_v_d  = s2_v_q;
    out_v_d = load ? 1'b1 : (rsp_o.ready ? 1'b0 : out_v_q);
    case (state_q)
      ST_CLEAR: begin
        idx_d = idx_q + HidW'(1);
        if (last_idx) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        idx_d = '0;
        if (accept) begin
          case (req.func)
            srme_pkg::FUNC_ADD_FEAT: begin
              if (row_ok) begin
                issue_d = 1'b1;
                state_d = ST_FEAT;
              end
            end
            srme_pkg::FUNC_EVAL: begin
              issue_d = 1'b1;
              state_d = ST_EVAL;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_FEAT, ST_EVAL: begin
        if (issue_q) begin
          idx_d = idx_q + HidW'(1);
          if (last_idx) begin
            idx_d   = '0;
            issue_d = 1'b0;
          end
        end
        if (state_q == ST_FEAT && !issue_q && !s1_v_q) begin
          state_d = ST_IDLE;
        end
        if (score_start) begin
          state_d = ST_SCORE;
        end
      end
      ST_SCORE: begin
        // waits for the score and for room in the output register
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      idx_q         <= '0;
      issue_q       <= 1'b0;
      s1_v_q        <= 1'b0;
      s2_v_q        <= 1'b0;
      s3_v_q        <= 1'b0;
      out_v_q       <= 1'b0;
      output_bias_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      issue_q <= issue_d;
      s1_v_q  <= s1_v_d;
      s2_v_q  <= s2_v_d;
      s3_v_q  <= s3_v_d;
      out_v_q <= out_v_d;
      if (cfg_we_i) begin
        output_bias_q <= cfg_wdata_i;
      end
    end
  end

  // walk datapath: relu value, product, then the running dot product
  always_ff @(posedge clk_i) begin
    s1_idx_q <= idx_q;
    if (accept) begin
      taddr_q <= row_base;
    end else if (wmem_re) begin
      taddr_q <= taddr_q + TabAddrW'(1);
    end
    if (s1_v_q) begin
      h_q  <= h_d;
      ow_q <= hmem_routw;
    end
    if (s2_v_q) begin
      prod_q <= ProdW'($signed(ow_q) * $signed({1'b0, h_q}));
    end
    if (accept && (req.func == srme_pkg::FUNC_EVAL)) begin
      sum_q <= sum_init;
    end else if (s3_v_q) begin
      sum_q <= sum_q + SumW'(prod_q);
    end
    if (load) begin
      out_q <= score_res;
    end
  end

  assign req_i.ready   = (state_q == ST_IDLE);
  assign rsp_o.valid   = out_v_q;
  assign rsp_o.payload = out_q;

endmodule

// ===== hw/rtl/srme_wmem.sv =====
module srme_wmem #(
  parameter int Depth = 65536,
  parameter int Width = 16,
  parameter int AddrW = 16
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/srme_hmem.sv =====
module srme_hmem #(
  parameter int Depth = 64,
  parameter int WBits = 16,
  parameter int AddrW = 6
) (
  input  logic                               clk_i,
  input  srme_pkg::hwr_en_t                  wen_i,
  input  logic [AddrW-1:0]                   waddr_i,
  input  logic signed [srme_pkg::AccW-1:0]   wacc_i,
  input  logic [WBits-1:0]                   wbias_i,
  input  logic [WBits-1:0]                   woutw_i,
  input  logic                               re_i,
  input  logic [AddrW-1:0]                   raddr_i,
  output logic signed [srme_pkg::AccW-1:0]   racc_o,
  output logic [WBits-1:0]                   rbias_o,
  output logic [WBits-1:0]                   routw_o
);

  localparam int AccW = srme_pkg::AccW;
  localparam int EntW = AccW + 2 * WBits;

  // entry layout: accumulator, hidden bias, output weight
  logic [EntW-1:0] mem_q [Depth];
  logic [EntW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wen_i.acc) begin
      mem_q[waddr_i][EntW-1 -: AccW] <= wacc_i;
    end
    if (wen_i.bias) begin
      mem_q[waddr_i][2*WBits-1 -: WBits] <= wbias_i;
    end
    if (wen_i.outw) begin
      mem_q[waddr_i][WBits-1:0] <= woutw_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign racc_o  = $signed(rdata_q[EntW-1 -: AccW]);
  assign rbias_o = rdata_q[2*WBits-1 -: WBits];
  assign routw_o = rdata_q[WBits-1:0];

endmodule

// ===== hw/rtl/srme_score.sv =====
module srme_score #(
  parameter int SumW = 38
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [SumW-1:0] sum_i,
  input  logic                   take_i,
  output logic                   valid_o,
  output srme_pkg::rsp_t         result_o
);

  localparam int ScW    = SumW + 4;
  localparam int ScoreW = srme_pkg::ScoreW;
  localparam int FracB  = srme_pkg::FracBits;

  localparam logic signed [ScW-1:0] ScaleOff = ScW'(srme_pkg::ScaleOffset);
  localparam logic signed [ScW-1:0] LowBnd   = ScW'(srme_pkg::LowBound);

  logic                  v1_q, v2_q, res_v_q;
  logic signed [ScW-1:0] t_q, u_q;
  srme_pkg::rsp_t        res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      if (v2_q) begin
        res_v_q <= 1'b1;
      end else if (take_i) begin
        res_v_q <= 1'b0;
      end
    end
  end

  // times seven, then one and the rounding half added
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      t_q <= (ScW'(sum_i) <<< 3) - ScW'(sum_i);
    end
    if (v1_q) begin
      u_q <= t_q + ScaleOff;
    end
    if (v2_q) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    if (u_q < LowBnd) begin
      res_d.score    = srme_pkg::ScoreMin;
      res_d.overflow = 1'b0;
    end else if (|u_q[ScW-1:ScoreW+FracB]) begin
      res_d.score    = srme_pkg::ScoreMax;
      res_d.overflow = 1'b1;
    end else begin
      res_d.score    = u_q[ScoreW+FracB-1:FracB];
      res_d.overflow = 1'b0;
    end
  end

  assign valid_o  = res_v_q;
  assign result_o = res_q;

endmodule

// ===== hw/rtl/srme_checker.sv =====
`include "sparse_input_relu_mlp_eval_core_macros.svh"

module srme_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [srme_pkg::FuncW-1:0]    in_func_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [srme_pkg::ScoreW-1:0]   out_score_i,
  input logic                          out_overflow_i
);

  // a waiting score stays offered
  `SRME_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // scores never fall below one half
  `SRME_ASSERT_NOW(a_score_floor, clk_i, rst_ni, out_valid_i, out_score_i >= srme_pkg::ScoreMin)

  // overflow only at the saturated score
  `SRME_ASSERT_NOW(a_ovf_max, clk_i, rst_ni, out_valid_i && out_overflow_i, out_score_i == srme_pkg::ScoreMax)

  // an evaluate word starts a walk, so no word is taken next cycle
  `SRME_ASSERT_NEXT(a_eval_busy, clk_i, rst_ni, in_valid_i && in_ready_i && (in_func_i == srme_pkg::FUNC_EVAL), !in_ready_i)

endmodule

bind sparse_input_relu_mlp_eval_core srme_checker u_srme_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (req_i.valid),
  .in_ready_i     (req_i.ready),
  .in_func_i      (req_i.payload.func),
  .out_valid_i    (rsp_o.valid),
  .out_ready_i    (rsp_o.ready),
  .out_score_i    (rsp_o.payload.score),
  .out_overflow_i (rsp_o.payload.overflow)
);
